// File: rtl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the block's checkers.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAB_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAB_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

// File: rtl/cab_pkg.sv
// ------------------------------------------------------------------------
// cab_pkg
// Types, register indexes and constants of the clipped alpha blend blit.
// ------------------------------------------------------------------------
package cab_pkg;

    localparam int CAB_COORD_BITS = 12;
    localparam int CAB_REG_W      = 13;
    localparam int CAB_IDX_W      = 3;
    localparam int CAB_PIX_W      = 32;
    localparam int CAB_INDEX_W    = 24;

    // Configuration register indexes.
    localparam logic [CAB_IDX_W-1:0] REG_DEST_WIDTH    = 3'd0;
    localparam logic [CAB_IDX_W-1:0] REG_DEST_HEIGHT   = 3'd1;
    localparam logic [CAB_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
    localparam logic [CAB_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
    localparam logic [CAB_IDX_W-1:0] REG_PLACE_X       = 3'd4;
    localparam logic [CAB_IDX_W-1:0] REG_PLACE_Y       = 3'd5;

    // Reset values.
    localparam logic [CAB_REG_W-1:0] RST_DEST_WIDTH    = 13'd640;
    localparam logic [CAB_REG_W-1:0] RST_DEST_HEIGHT   = 13'd480;
    localparam logic [CAB_REG_W-1:0] RST_SOURCE_WIDTH  = 13'd1;
    localparam logic [CAB_REG_W-1:0] RST_SOURCE_HEIGHT = 13'd1;
    localparam logic [CAB_REG_W-1:0] RST_PLACE         = 13'd0;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [CAB_REG_W-1:0] dest_width;
        logic [CAB_REG_W-1:0] dest_height;
        logic [CAB_REG_W-1:0] source_width;
        logic [CAB_REG_W-1:0] source_height;
        logic [CAB_REG_W-1:0] place_x;
        logic [CAB_REG_W-1:0] place_y;
    } cab_cfg_t;

    // Placement of one pixel: row and column are meaningful when in_raster is set.
    typedef struct packed {
        logic                 in_raster;
        logic                 last;
        logic [CAB_REG_W-1:0] row;
        logic [CAB_REG_W-1:0] col;
    } cab_pos_t;

endpackage

// File: rtl/cab_ifs.sv
// ------------------------------------------------------------------------
// cab interfaces
// Valid/ready channels for pixels in, results out and register writes.
// ------------------------------------------------------------------------
interface cab_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_pixel;
    logic [31:0] dest_pixel;

    modport source (output valid, source_pixel, dest_pixel, input ready);
    modport sink   (input valid, source_pixel, dest_pixel, output ready);
endinterface

interface cab_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] dest_index;
    logic        write_enable;
    logic [31:0] blended_pixel;
    logic        last_pixel;

    modport source (output valid, dest_index, write_enable, blended_pixel, last_pixel,
                    input ready);
    modport sink   (input valid, dest_index, write_enable, blended_pixel, last_pixel,
                    output ready);
endinterface

interface cab_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/clipped_alpha_blend_blit_top.sv
// ------------------------------------------------------------------------
// clipped_alpha_blend_blit_top
// Alpha-blends a streamed ARGB8888 source image onto a clipped raster.
// ------------------------------------------------------------------------
// Usage: source pixels arrive on the pixels channel in raster order, each
// transfer carrying the source pixel and the destination pixel currently
// stored at the target location. Every pixel transfer yields exactly one
// transfer on the results channel with the destination index, a write
// enable that is low for clipped pixels (index then reads zero), the
// blended pixel and a flag on the final pixel of the image.
// Registers are written on the cfg channel, which is always ready; they
// should only change while no pixel is in flight.
// A pixel is held first in the input register and then in the result
// register, which drives the results channel.
// While the receiver keeps ready high, a pixel can be taken every cycle,
// so throughput is one pixel per clock; it is set by the result register,
// which takes a new value whenever it is empty or being drained in the
// same cycle.
// When the receiver stalls, the result register holds its transfer and the
// input register fills; pixels then wait until the result is taken.
// Reset clears both pipeline stages, the column and row counters (the next
// pixel starts a new image) and loads the register defaults.
// ------------------------------------------------------------------------
module clipped_alpha_blend_blit_top
    import cab_pkg::*;
#(
    parameter int COORD_BITS = CAB_COORD_BITS
)
(
    input  logic            clk,
    input  logic            rst_n,
    cab_pix_if.sink         pixels,
    cab_res_if.source       results,
    cab_cfg_if.sink         cfg
);

    cab_cfg_t cfg_q;
    cab_pos_t pos;
    logic     pix_take;
    logic     s1_ready;
    logic     out_load;

    // Input stage registers.
    logic                 s1_valid_reg;
    logic [CAB_PIX_W-1:0] s1_src_reg;
    logic [CAB_PIX_W-1:0] s1_dst_reg;
    cab_pos_t             s1_pos_reg;

    // Result stage registers.
    logic                   out_valid_reg;
    logic [CAB_INDEX_W-1:0] out_index_reg;
    logic                   out_we_reg;
    logic [CAB_PIX_W-1:0]   out_pixel_reg;
    logic                   out_last_reg;

    // Result stage inputs.
    logic [CAB_PIX_W-1:0]     blended;
    logic [2*CAB_REG_W-1:0]   row_base;
    logic [CAB_INDEX_W-1:0]   index_next;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    cab_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // The result register loads when empty or when its transfer completes.
    assign out_load = !out_valid_reg || results.ready;
    assign s1_ready = !s1_valid_reg || out_load;
    assign pixels.ready = s1_ready;
    assign pix_take = pixels.valid && s1_ready;

    // Counters advance with each pixel transfer.
    cab_addr_gen #(
        .COORD_BITS (COORD_BITS)
    ) u_addr_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (pix_take),
        .cfg   (cfg_q),
        .pos   (pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pixels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            s1_src_reg <= pixels.source_pixel;
            s1_dst_reg <= pixels.dest_pixel;
            s1_pos_reg <= pos;
        end
    end

    cab_blend u_blend (
        .src   (s1_src_reg),
        .dst   (s1_dst_reg),
        .pixel (blended)
    );

    // Row and column are below the raster size whenever the pixel is inside.
    assign row_base   = (2*CAB_REG_W)'(s1_pos_reg.row) * (2*CAB_REG_W)'(cfg_q.dest_width);
    assign index_next = s1_pos_reg.in_raster ?
                        CAB_INDEX_W'(row_base + (2*CAB_REG_W)'(s1_pos_reg.col)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_index_reg <= index_next;
            out_we_reg    <= s1_pos_reg.in_raster;
            out_pixel_reg <= blended;
            out_last_reg  <= s1_pos_reg.last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.dest_index    = out_index_reg;
    assign results.write_enable  = out_we_reg;
    assign results.blended_pixel = out_pixel_reg;
    assign results.last_pixel    = out_last_reg;

endmodule

// File: rtl/cab_cfg_regs.sv
// ------------------------------------------------------------------------
// cab_cfg_regs
// Configuration register file written through the register channel.
// ------------------------------------------------------------------------
module cab_cfg_regs
    import cab_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CAB_IDX_W-1:0] wr_index,
    input  logic [CAB_REG_W-1:0] wr_data,
    output cab_cfg_t             cfg
);

    cab_cfg_t cfg_reg;
    cab_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_DEST_WIDTH:    cfg_next.dest_width    = wr_data;
                REG_DEST_HEIGHT:   cfg_next.dest_height   = wr_data;
                REG_SOURCE_WIDTH:  cfg_next.source_width  = wr_data;
                REG_SOURCE_HEIGHT: cfg_next.source_height = wr_data;
                REG_PLACE_X:       cfg_next.place_x       = wr_data;
                REG_PLACE_Y:       cfg_next.place_y       = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_width    <= RST_DEST_WIDTH;
            cfg_reg.dest_height   <= RST_DEST_HEIGHT;
            cfg_reg.source_width  <= RST_SOURCE_WIDTH;
            cfg_reg.source_height <= RST_SOURCE_HEIGHT;
            cfg_reg.place_x       <= RST_PLACE;
            cfg_reg.place_y       <= RST_PLACE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/cab_addr_gen.sv
// ------------------------------------------------------------------------
// cab_addr_gen
// Source column/row counters, placement, clipping and end-of-image flag.
// ------------------------------------------------------------------------
module cab_addr_gen
    import cab_pkg::*;
#(
    parameter int COORD_BITS = CAB_COORD_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  cab_cfg_t cfg,
    output cab_pos_t pos
);

    localparam int CMP_W = (COORD_BITS + 1 > CAB_REG_W) ? COORD_BITS + 1 : CAB_REG_W;
    localparam int POS_W = ((COORD_BITS > CAB_REG_W) ? COORD_BITS : CAB_REG_W) + 2;

    logic [COORD_BITS-1:0]   column_reg;
    logic [COORD_BITS-1:0]   column_next;
    logic [COORD_BITS-1:0]   row_reg;
    logic [COORD_BITS-1:0]   row_next;
    logic [COORD_BITS:0]     column_inc;
    logic [COORD_BITS:0]     row_inc;
    logic                    row_end;
    logic                    img_end;
    logic signed [POS_W-1:0] col_pos;
    logic signed [POS_W-1:0] row_pos;

    assign column_inc = {1'b0, column_reg} + (COORD_BITS + 1)'(1);
    assign row_inc    = {1'b0, row_reg} + (COORD_BITS + 1)'(1);

    // A size of zero behaves like one; counters also wrap at their top value.
    assign row_end = (CMP_W'(column_inc) >= CMP_W'(cfg.source_width)) || (&column_reg);
    assign img_end = row_end &&
                     ((CMP_W'(row_inc) >= CMP_W'(cfg.source_height)) || (&row_reg));

    assign col_pos = POS_W'($signed(cfg.place_x)) + $signed(POS_W'(column_reg));
    assign row_pos = POS_W'($signed(cfg.place_y)) + $signed(POS_W'(row_reg));

    always_comb
    begin
        pos.in_raster = !col_pos[POS_W-1] && !row_pos[POS_W-1] &&
                        (col_pos < $signed(POS_W'(cfg.dest_width))) &&
                        (row_pos < $signed(POS_W'(cfg.dest_height)));
        pos.last      = img_end;
        pos.col       = col_pos[CAB_REG_W-1:0];
        pos.row       = row_pos[CAB_REG_W-1:0];
    end

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (step)
        begin
            if (row_end)
            begin
                column_next = '0;
                row_next    = img_end ? '0 : row_inc[COORD_BITS-1:0];
            end
            else
            begin
                column_next = column_inc[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: rtl/cab_blend.sv
// ------------------------------------------------------------------------
// cab_blend
// Per-channel ARGB8888 alpha blend with exact truncating divide by 255.
// ------------------------------------------------------------------------
module cab_blend
    import cab_pkg::*;
(
    input  logic [CAB_PIX_W-1:0] src,
    input  logic [CAB_PIX_W-1:0] dst,
    output logic [CAB_PIX_W-1:0] pixel
);

    logic [7:0]  alpha;
    logic [7:0]  inv_alpha;
    logic [23:0] color;

    assign alpha     = src[31:24];
    assign inv_alpha = ALPHA_OPAQUE - alpha;

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        logic [16:0] mix;
        logic [16:0] quot;

        // mix never exceeds 255*255, where (x + 1 + x/256) / 256 equals x / 255.
        assign mix  = 17'(16'(src[8*ch +: 8]) * 16'(alpha)) +
                      17'(16'(dst[8*ch +: 8]) * 16'(inv_alpha));
        assign quot = mix + 17'(1) + 17'(mix[16:8]);
        assign color[8*ch +: 8] = quot[15:8];
    end

    assign pixel = (alpha == ALPHA_OPAQUE) ? src : {alpha, color};

endmodule

// File: rtl/cab_checker.sv
// ------------------------------------------------------------------------
// cab_checker
// Port-level checks of the blit, attached to the top level by bind.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module cab_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        pix_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [23:0] res_index,
    input logic        res_we,
    input logic [31:0] res_pixel,
    input logic        res_last
);

    // A clipped result always carries a zero index.
    `CAB_ASSERT_NOW(a_clip_index_zero, clk, rst_n, res_valid && !res_we, res_index == 24'd0)

    // With the result register empty, a pixel can always be taken.
    `CAB_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !res_valid, pix_ready)

    // A stalled result holds.
    `CAB_ASSERT_NEXT(a_result_holds, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_index) && $stable(res_we) && $stable(res_pixel) && $stable(res_last))

endmodule

bind clipped_alpha_blend_blit_top cab_checker u_cab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_ready (pixels.ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_index (results.dest_index),
    .res_we    (results.write_enable),
    .res_pixel (results.blended_pixel),
    .res_last  (results.last_pixel)
);

// File: tb/clipped_alpha_blend_blit_top_tb.sv
// ------------------------------------------------------------------------
// clipped_alpha_blend_blit_top_tb
// Self-checking bench: streams ARGB pixel pairs under changing raster
// settings and checks every destination write against a local predictor.
// ------------------------------------------------------------------------
import cab_pkg::*;

// One predicted or observed transfer on the results channel.
typedef struct packed {
    logic [CAB_INDEX_W-1:0] dest_index;
    logic                   write_enable;
    logic [CAB_PIX_W-1:0]   blended_pixel;
    logic                   last_pixel;
} blit_write_t;

class blit_scoreboard;
    logic [CAB_REG_W-1:0]      dest_width;
    logic [CAB_REG_W-1:0]      dest_height;
    logic [CAB_REG_W-1:0]      source_width;
    logic [CAB_REG_W-1:0]      source_height;
    logic [CAB_REG_W-1:0]      place_x;
    logic [CAB_REG_W-1:0]      place_y;
    logic [CAB_COORD_BITS-1:0] column;
    logic [CAB_COORD_BITS-1:0] row_count;
    blit_write_t               expected_writes[$];
    int                        errors;
    int                        pixels_in;
    int                        images_done;
    int                        writes_seen;
    int                        clipped_seen;

    function new();
        dest_width    = RST_DEST_WIDTH;
        dest_height   = RST_DEST_HEIGHT;
        source_width  = RST_SOURCE_WIDTH;
        source_height = RST_SOURCE_HEIGHT;
        place_x       = RST_PLACE;
        place_y       = RST_PLACE;
        column        = '0;
        row_count     = '0;
        errors        = 0;
        pixels_in     = 0;
        images_done   = 0;
        writes_seen   = 0;
        clipped_seen  = 0;
    endfunction

    function void write_reg(logic [CAB_IDX_W-1:0] idx, logic [CAB_REG_W-1:0] data);
        case (idx)
            REG_DEST_WIDTH:    dest_width    = data;
            REG_DEST_HEIGHT:   dest_height   = data;
            REG_SOURCE_WIDTH:  source_width  = data;
            REG_SOURCE_HEIGHT: source_height = data;
            REG_PLACE_X:       place_x       = data;
            REG_PLACE_Y:       place_y       = data;
            default: ;
        endcase
    endfunction

    // Source-over blend with truncating division; opaque pixels are copied.
    function logic [31:0] mix_argb(logic [31:0] s, logic [31:0] d);
        int unsigned a;
        int unsigned sc;
        int unsigned dc;
        int unsigned c;
        logic [31:0] r;
        int          k;
        a = s[31:24];
        if (s[31:24] == ALPHA_OPAQUE)
            return s;
        r = {s[31:24], 24'h0};
        for (k = 0; k < 3; k++)
        begin
            sc = s[8*k +: 8];
            dc = d[8*k +: 8];
            c  = (dc * (255 - a) + sc * a) / 255;
            r[8*k +: 8] = c[7:0];
        end
        return r;
    endfunction

    function blit_write_t predict_write(logic [31:0] s, logic [31:0] d);
        int          col_pos;
        int          row_pos;
        int          dw;
        int          dh;
        int          sw;
        int          sh;
        bit          in_raster;
        bit          row_end;
        bit          image_end;
        logic [31:0] linear;
        blit_write_t w;
        dw = dest_width;
        dh = dest_height;
        sw = source_width;
        sh = source_height;
        col_pos = int'($signed(place_x)) + int'(column);
        row_pos = int'($signed(place_y)) + int'(row_count);
        in_raster = col_pos >= 0 && row_pos >= 0 && col_pos < dw && row_pos < dh;
        row_end   = (int'(column) + 1 >= sw) || (column == '1);
        image_end = row_end && ((int'(row_count) + 1 >= sh) || (row_count == '1));
        linear = row_pos * dw + col_pos;
        w.dest_index    = in_raster ? linear[CAB_INDEX_W-1:0] : '0;
        w.write_enable  = in_raster;
        w.blended_pixel = mix_argb(s, d);
        w.last_pixel    = image_end;
        if (row_end)
        begin
            column    = '0;
            row_count = image_end ? '0 : row_count + 1'b1;
        end
        else
            column = column + 1'b1;
        return w;
    endfunction

    function void note_input(logic [31:0] s, logic [31:0] d);
        expected_writes.push_back(predict_write(s, d));
        pixels_in++;
    endfunction

    task report(string what);
        if (errors < 25)
            $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    task check_write(blit_write_t got);
        blit_write_t want;
        if (expected_writes.size() == 0)
        begin
            report($sformatf("result with nothing pending, index %0h", got.dest_index));
            return;
        end
        want = expected_writes.pop_front();
        if (got.dest_index !== want.dest_index)
            report($sformatf("dest_index %0h, expected %0h", got.dest_index, want.dest_index));
        if (got.write_enable !== want.write_enable)
            report($sformatf("write_enable %b, expected %b",
                             got.write_enable, want.write_enable));
        if (got.blended_pixel !== want.blended_pixel)
            report($sformatf("blended_pixel %h, expected %h",
                             got.blended_pixel, want.blended_pixel));
        if (got.last_pixel !== want.last_pixel)
            report($sformatf("last_pixel %b, expected %b", got.last_pixel, want.last_pixel));
        if (want.last_pixel)
            images_done++;
        if (want.write_enable)
            writes_seen++;
        else
            clipped_seen++;
    endtask

    function int pending();
        return expected_writes.size();
    endfunction
endclass

module clipped_alpha_blend_blit_top_tb;

    // Indexes that no register answers to; writes to them must be ignored.
    localparam logic [CAB_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CAB_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam int RANDOM_PIXELS = 1000;

    logic clk;
    logic rst_n;

    cab_pix_if pix_ch();
    cab_res_if res_ch();
    cab_cfg_if cfg_ch();

    blit_scoreboard sb;

    // When set, both sides run at full rate with no idling at all.
    bit steady_flow;
    int stall_left;
    int settings_used;
    int random_sent;

    clipped_alpha_blend_blit_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Gap lengths: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side. The result fields are sampled at the edge, before any of
    // this edge's updates land, and ready is driven for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_write({res_ch.dest_index, res_ch.write_enable,
                            res_ch.blended_pixel, res_ch.last_pixel});
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (steady_flow)
            res_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Present one pixel pair and hold it until the block takes the transfer.
    // Valid is left high so that a following pixel can go out back to back.
    task automatic send_pixel(input logic [31:0] s, input logic [31:0] d);
        pix_ch.valid        <= 1'b1;
        pix_ch.source_pixel <= s;
        pix_ch.dest_pixel   <= d;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        sb.note_input(s, d);
    endtask

    task automatic pixel_gap(input int n);
        if (n > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_paced(input logic [31:0] s, input logic [31:0] d);
        send_pixel(s, d);
        pixel_gap(steady_flow ? 0 : pick_gap());
    endtask

    // Stop sending, let every outstanding result come back through the
    // two-stage pipeline, and then idle before returning.
    task automatic wait_drain();
        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the full register set while nothing is in flight, optionally
    // followed by writes to the two unused indexes.
    task automatic program_regs(input logic [12:0] dw, input logic [12:0] dh,
                                input logic [12:0] sw, input logic [12:0] sh,
                                input logic [12:0] px, input logic [12:0] py,
                                input bit with_unused);
        logic [CAB_IDX_W-1:0] idx_list[8];
        logic [CAB_REG_W-1:0] val_list[8];
        int                   n;
        int                   i;
        wait_drain();
        idx_list[0] = REG_DEST_WIDTH;    val_list[0] = dw;
        idx_list[1] = REG_DEST_HEIGHT;   val_list[1] = dh;
        idx_list[2] = REG_SOURCE_WIDTH;  val_list[2] = sw;
        idx_list[3] = REG_SOURCE_HEIGHT; val_list[3] = sh;
        idx_list[4] = REG_PLACE_X;       val_list[4] = px;
        idx_list[5] = REG_PLACE_Y;       val_list[5] = py;
        n = 6;
        if (with_unused)
        begin
            idx_list[6] = REG_UNUSED_LO; val_list[6] = 13'($urandom);
            idx_list[7] = REG_UNUSED_HI; val_list[7] = 13'($urandom);
            n = 8;
        end
        for (i = 0; i < n; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx_list[i];
            cfg_ch.data  <= val_list[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            sb.write_reg(idx_list[i], val_list[i]);
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Alpha is biased toward the opaque, transparent and near-limit cases.
    function automatic logic [31:0] random_pixel();
        logic [31:0] p;
        int          roll;
        p    = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            p[31:24] = 8'hFF;
        else if (roll < 35)
            p[31:24] = 8'h00;
        else if (roll < 45)
            p[31:24] = roll[0] ? 8'hFE : 8'h01;
        return p;
    endfunction

    function automatic logic [12:0] random_dest_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 13'($urandom_range(1, 20));
        if (roll < 70)
            return 13'd0;
        if (roll < 85)
            return 13'($urandom_range(1, 4096));
        return 13'($urandom);
    endfunction

    function automatic logic [12:0] random_source_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return 13'($urandom_range(1, 6));
        if (roll < 90)
            return 13'($urandom_range(7, 32));
        if (roll < 95)
            return 13'd0;
        return 13'($urandom);
    endfunction

    // Place the image near the raster so that it straddles an edge, or
    // anywhere in the signed range.
    function automatic logic [12:0] random_place(input logic [12:0] dsize,
                                                 input logic [12:0] ssize);
        int lo;
        int hi;
        if ($urandom_range(0, 99) < 25)
            return 13'($urandom);
        lo = (ssize > 40) ? 40 : int'(ssize);
        hi = (dsize > 40) ? 40 : int'(dsize);
        return 13'($urandom_range(0, lo + hi) - lo);
    endfunction

    // One random setting followed by a stream of pixels: mostly a few whole
    // images, sometimes a partial one, so settings also change mid-image.
    task automatic random_phase();
        logic [12:0] dw;
        logic [12:0] dh;
        logic [12:0] sw;
        logic [12:0] sh;
        int          span;
        int          count;
        int          pause_at;
        int          i;
        dw = random_dest_size();
        dh = random_dest_size();
        sw = random_source_size();
        sh = random_source_size();
        program_regs(dw, dh, sw, sh, random_place(dw, sw), random_place(dh, sh),
                     $urandom_range(0, 9) == 0);
        steady_flow = ($urandom_range(0, 4) == 0);
        span = ((sw == 0) ? 1 : int'(sw)) * ((sh == 0) ? 1 : int'(sh));
        if (span > 60)
            count = $urandom_range(1, 120);
        else if ($urandom_range(0, 3) == 0)
            count = $urandom_range(1, 3 * span);
        else
            count = span * $urandom_range(1, 3);
        pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;
        for (i = 0; i < count; i++)
        begin
            if (i == pause_at)
                wait_drain();
            send_paced(random_pixel(), $urandom);
        end
        random_sent += count;
    endtask

    initial
    begin
        sb            = new();
        steady_flow   = 1'b0;
        stall_left    = 0;
        settings_used = 0;
        random_sent   = 0;
        rst_n               <= 1'b0;
        pix_ch.valid        <= 1'b0;
        pix_ch.source_pixel <= '0;
        pix_ch.dest_pixel   <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_DEST_WIDTH;
        cfg_ch.data         <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: a one-pixel image at the raster origin, so each
        // pixel is the last one. Copy, transparent and near-limit alphas.
        send_paced(32'hFFFF_FFFF, 32'h0000_0000);
        send_paced(32'h00FF_FFFF, 32'hFFFF_FFFF);
        send_paced(32'h0100_0000, 32'hFFFF_FFFF);
        send_paced(32'hFEFF_FFFF, 32'h0000_0000);
        send_paced(32'h8012_34AB, 32'hC0FE_DC01);

        // A 3x3 image placed one up and one left of a 4x3 raster: the top
        // row and left column are clipped, the rest lands inside.
        program_regs(13'd4, 13'd3, 13'd3, 13'd3, -13'sd1, -13'sd1, 1'b1);
        repeat (9) send_paced(random_pixel(), $urandom);

        // Largest raster with the image placed at its middle: the linear index
        // overflows and keeps only its low bits.
        program_regs(13'h1FFF, 13'h1FFF, 13'd2, 13'd1, 13'd4095, 13'd4095, 1'b0);
        send_paced(random_pixel(), $urandom);
        send_paced(random_pixel(), $urandom);

        // Zero sizes: a zero source size acts as one and a zero raster width or
        // height clips every pixel; the most negative placement too.
        program_regs(13'd0, 13'd5, 13'd0, 13'd0, 13'h1000, 13'h1000, 1'b0);
        repeat (3) send_paced(random_pixel(), $urandom);
        program_regs(13'd5, 13'd0, 13'd2, 13'd1, 13'd0, 13'd0, 1'b0);
        repeat (2) send_paced(random_pixel(), $urandom);

        // Settings change in the middle of an image: the position counters
        // carry on and the new placement applies from the next pixel.
        program_regs(13'd8, 13'd8, 13'd3, 13'd2, 13'd1, 13'd1, 1'b0);
        repeat (2) send_paced(random_pixel(), $urandom);
        program_regs(13'd8, 13'd8, 13'd3, 13'd2, 13'd6, 13'd1, 1'b0);
        repeat (4) send_paced(random_pixel(), $urandom);

        // Sizes beyond the counter range: a very long row and then a very tall
        // column at full rate, with no image end and no row end in the long row.
        steady_flow = 1'b1;
        program_regs(13'd5000, 13'd5, 13'd6000, 13'd1, 13'd0, 13'd0, 1'b0);
        repeat (100) send_paced(random_pixel(), $urandom);
        program_regs(13'd4, 13'd5000, 13'd1, 13'd6000, 13'd0, 13'd0, 1'b0);
        repeat (100) send_paced(random_pixel(), $urandom);
        steady_flow = 1'b0;

        while (random_sent < RANDOM_PIXELS)
            random_phase();

        wait_drain();
        $display("Checked %0d pixel transfers over %0d register settings.",
                 sb.pixels_in, settings_used);
        $display("%0d images completed, %0d pixels written, %0d clipped.",
                 sb.images_done, sb.writes_seen, sb.clipped_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #40_000_000;
        $display("Timed out with %0d results outstanding.", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/cab_pkg.sv
rtl/cab_ifs.sv
rtl/cab_cfg_regs.sv
rtl/cab_addr_gen.sv
rtl/cab_blend.sv
rtl/clipped_alpha_blend_blit_top.sv
rtl/cab_checker.sv
tb/clipped_alpha_blend_blit_top_tb.sv
